@@ rtl/ald_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light lamp dimmer package
// Shared types, codes, reset values and constant tables of the dimmer.
// ----------------------------------------------------------------------------
package ald_pkg;

    // Tick kinds carried by a request.
    localparam logic [1:0] KIND_FAST   = 2'd0;
    localparam logic [1:0] KIND_MEDIUM = 2'd1;
    localparam logic [1:0] KIND_RAMP   = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_NIGHT  = 2'd0;
    localparam logic [1:0] REG_DUSK   = 2'd1;
    localparam logic [1:0] REG_DIM    = 2'd2;
    localparam logic [1:0] REG_BRIGHT = 2'd3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int THR_W  = 10;
    localparam int LEVEL_W = 7;

    localparam logic [THR_W-1:0] NIGHT_RESET  = 10'd850;
    localparam logic [THR_W-1:0] DUSK_RESET   = 10'd500;
    localparam logic [THR_W-1:0] DIM_RESET    = 10'd300;
    localparam logic [THR_W-1:0] BRIGHT_RESET = 10'd150;

    // Light bands; the none code marks that no sample has been sorted yet.
    localparam logic [2:0] BAND_DEEP_NIGHT = 3'd0;
    localparam logic [2:0] BAND_NIGHT      = 3'd1;
    localparam logic [2:0] BAND_LIGHT_DAY  = 3'd2;
    localparam logic [2:0] BAND_DAY        = 3'd3;
    localparam logic [2:0] BAND_BRIGHT_DAY = 3'd4;
    localparam logic [2:0] BAND_NONE       = 3'd7;

    localparam logic [LEVEL_W-1:0] DUTY_MAX = 7'd100;

    localparam int RAMP_STEPS_DEFAULT       = 10;
    localparam int DEBOUNCE_SAMPLES_DEFAULT = 5;

    // Profile entries are stored pre-scaled by 5243 = ceil(2^19 / 100), so
    // that (span * entry) >> 19 equals floor(profile * span / 100) exactly.
    localparam int PROFILE_SHIFT = 19;
    localparam int PROFILE_W     = 20;

    typedef struct packed {
        logic [1:0]       kind;
        logic             button_low;
        logic [THR_W-1:0] light_sample;
    } ald_in_t;

    typedef struct packed {
        logic               lamp_enabled;
        logic [LEVEL_W-1:0] duty_percent;
        logic               duty_written;
        logic               night_led;
        logic               day_led;
        logic               sample_request;
    } ald_out_t;

    function automatic logic [PROFILE_W-1:0] profile_scaled(input logic [4:0] step);
        logic [PROFILE_W-1:0] value;
        case (step)
            5'd0:    value = 20'd0;
            5'd1:    value = 20'd52430;
            5'd2:    value = 20'd104860;
            5'd3:    value = 20'd419440;
            5'd4:    value = 20'd681590;
            5'd5:    value = 20'd681590;
            5'd6:    value = 20'd629160;
            5'd7:    value = 20'd576730;
            5'd8:    value = 20'd550515;
            default: value = 20'd524300;
        endcase
        return value;
    endfunction

    function automatic logic [LEVEL_W-1:0] band_level(input logic [2:0] band);
        logic [LEVEL_W-1:0] level;
        case (band)
            BAND_DEEP_NIGHT: level = 7'd15;
            BAND_NIGHT:      level = 7'd20;
            BAND_LIGHT_DAY:  level = 7'd42;
            BAND_DAY:        level = 7'd80;
            default:         level = 7'd90;
        endcase
        return level;
    endfunction

endpackage

@@ rtl/ambient_light_lamp_dimmer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light lamp dimmer
// Button debounce and lamp toggle, light banding and overshoot duty ramp.
// ----------------------------------------------------------------------------
// The dimmer takes one tick request per clock cycle while no result waits
// untaken, and returns exactly one result per request. A request is evaluated
// against the current state in the cycle it is accepted, and its result is
// captured in the output register and held there until it is taken.
// The path that sets the clock is the ramp tick: one 7 by 20 bit multiply of
// the ramp span by a pre-scaled profile entry, an add or subtract and a clamp.
// The output register frees as soon as its result is taken, so a new request
// is accepted in the same cycle that the previous result leaves. Fast ticks
// debounce the active-low button over DEBOUNCE_SAMPLES samples and toggle the
// lamp on each press; while the lamp is on, medium ticks sort the light
// sample into five bands by the four thresholds; ramp ticks walk a 2*RAMP_STEPS tick ramp.
// Threshold registers sit at byte addresses 0, 4, 8 and 12 and should only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module ambient_light_lamp_dimmer_top #(
    parameter int RAMP_STEPS       = ald_pkg::RAMP_STEPS_DEFAULT,
    parameter int DEBOUNCE_SAMPLES = ald_pkg::DEBOUNCE_SAMPLES_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Tick request channel.
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ald_pkg::ald_in_t          in_item,
    // Result channel.
    output logic                      out_valid,
    input  logic                      out_ready,
    output ald_pkg::ald_out_t         out_item,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ald_pkg::ADDR_W-1:0] paddr,
    input  logic [ald_pkg::DATA_W-1:0] pwdata,
    output logic [ald_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);

    // The step counter must be able to hold RAMP_STEPS itself.
    localparam int STEP_W = $clog2(RAMP_STEPS + 1);
    localparam int HIST_W = DEBOUNCE_SAMPLES;
    localparam int PROD_W = ald_pkg::LEVEL_W + ald_pkg::PROFILE_W;
    localparam int VAL_W  = 10;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ald_pkg::THR_W-1:0] night_thr_reg;
    logic [ald_pkg::THR_W-1:0] dusk_thr_reg;
    logic [ald_pkg::THR_W-1:0] dim_thr_reg;
    logic [ald_pkg::THR_W-1:0] bright_thr_reg;
    logic                      cfg_write;
    logic [1:0]                cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_thr_reg  <= ald_pkg::NIGHT_RESET;
            dusk_thr_reg   <= ald_pkg::DUSK_RESET;
            dim_thr_reg    <= ald_pkg::DIM_RESET;
            bright_thr_reg <= ald_pkg::BRIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ald_pkg::REG_NIGHT:  night_thr_reg  <= pwdata[ald_pkg::THR_W-1:0];
                ald_pkg::REG_DUSK:   dusk_thr_reg   <= pwdata[ald_pkg::THR_W-1:0];
                ald_pkg::REG_DIM:    dim_thr_reg    <= pwdata[ald_pkg::THR_W-1:0];
                ald_pkg::REG_BRIGHT: bright_thr_reg <= pwdata[ald_pkg::THR_W-1:0];
                default:             night_thr_reg  <= night_thr_reg;
            endcase
        end
    end

    // Reads are answered directly from the registers.
    always_comb
    begin
        case (cfg_index)
            ald_pkg::REG_NIGHT:  prdata = {22'd0, night_thr_reg};
            ald_pkg::REG_DUSK:   prdata = {22'd0, dusk_thr_reg};
            ald_pkg::REG_DIM:    prdata = {22'd0, dim_thr_reg};
            ald_pkg::REG_BRIGHT: prdata = {22'd0, bright_thr_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Dimmer state.
    // ------------------------------------------------------------------
    logic [HIST_W-1:0]          hist_reg,      hist_next;
    logic                       pressed_reg,   pressed_next;
    logic                       was_reg,       was_next;
    logic                       lamp_reg,      lamp_next;
    logic [2:0]                 band_reg,      band_next;
    logic [ald_pkg::LEVEL_W-1:0] level_reg,    level_next;
    logic [ald_pkg::LEVEL_W-1:0] settled_reg,  settled_next;
    logic [ald_pkg::LEVEL_W-1:0] span_reg,     span_next;
    logic                       rising_reg,    rising_next;
    logic                       phase_reg,     phase_next;
    logic [STEP_W-1:0]          step_reg,      step_next;
    logic                       ramping_reg,   ramping_next;
    logic [ald_pkg::LEVEL_W-1:0] duty_reg,     duty_next;
    logic                       night_reg,     night_next;
    logic                       day_reg,       day_next;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    ald_pkg::ald_out_t          out_item_reg,  out_item_next;

    logic                       accept;
    logic [HIST_W-1:0]          hist_shift;
    logic [2:0]                 band_sel;
    logic [ald_pkg::LEVEL_W-1:0] sel_level;
    logic [PROD_W-1:0]          ramp_prod;
    logic [7:0]                 ramp_delta;
    logic signed [VAL_W-1:0]    ramp_val;
    logic [ald_pkg::LEVEL_W-1:0] ramp_duty;
    logic [STEP_W-1:0]          step_inc;
    logic                       written;
    logic                       request;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The newest debounce sample enters at the bottom; 1 means held down.
    assign hist_shift = {hist_reg[HIST_W-2:0], ~in_item.button_low};

    // Higher samples are darker; the first threshold exceeded picks the band.
    always_comb
    begin
        if (in_item.light_sample > night_thr_reg)
            band_sel = ald_pkg::BAND_DEEP_NIGHT;
        else if (in_item.light_sample > dusk_thr_reg)
            band_sel = ald_pkg::BAND_NIGHT;
        else if (in_item.light_sample > dim_thr_reg)
            band_sel = ald_pkg::BAND_LIGHT_DAY;
        else if (in_item.light_sample > bright_thr_reg)
            band_sel = ald_pkg::BAND_DAY;
        else
            band_sel = ald_pkg::BAND_BRIGHT_DAY;
    end

    assign sel_level = ald_pkg::band_level(band_sel);

    // Overshoot offset: floor(profile * span / 100) through the pre-scaled
    // profile table, then applied toward the band level and clamped.
    assign ramp_prod  = PROD_W'(span_reg) * PROD_W'(ald_pkg::profile_scaled(5'(step_reg)));
    assign ramp_delta = ramp_prod[ald_pkg::PROFILE_SHIFT +: 8];

    always_comb
    begin
        if (rising_reg)
            ramp_val = $signed({3'd0, settled_reg}) + $signed({2'd0, ramp_delta});
        else
            ramp_val = $signed({3'd0, settled_reg}) - $signed({2'd0, ramp_delta});

        if (ramp_val < 0)
            ramp_duty = '0;
        else if (ramp_val > $signed({3'd0, ald_pkg::DUTY_MAX}))
            ramp_duty = ald_pkg::DUTY_MAX;
        else
            ramp_duty = ramp_val[ald_pkg::LEVEL_W-1:0];
    end

    // The step advances after every second ramp tick.
    assign step_inc = phase_reg ? step_reg + STEP_W'(1) : step_reg;

    always_comb
    begin
        hist_next    = hist_reg;
        pressed_next = pressed_reg;
        was_next     = was_reg;
        lamp_next    = lamp_reg;
        band_next    = band_reg;
        level_next   = level_reg;
        settled_next = settled_reg;
        span_next    = span_reg;
        rising_next  = rising_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        ramping_next = ramping_reg;
        duty_next    = duty_reg;
        night_next   = night_reg;
        day_next     = day_reg;
        written      = 1'b0;
        request      = 1'b0;

        case (in_item.kind)
            ald_pkg::KIND_FAST:
            begin
                hist_next = hist_shift;
                if (hist_shift == '1)
                    pressed_next = 1'b1;
                else if (hist_shift == '0)
                    pressed_next = 1'b0;
                if (pressed_next && !was_reg)
                begin
                    lamp_next = !lamp_reg;
                    // Switching off darkens the indicators and the lamp.
                    if (lamp_reg)
                    begin
                        night_next = 1'b0;
                        day_next   = 1'b0;
                        duty_next  = '0;
                        written    = 1'b1;
                    end
                end
                was_next = pressed_next;
                request  = lamp_next;
            end
            ald_pkg::KIND_MEDIUM:
            begin
                if (lamp_reg)
                begin
                    if (band_sel != band_reg)
                    begin
                        band_next    = band_sel;
                        level_next   = sel_level;
                        rising_next  = sel_level >= settled_reg;
                        span_next    = (sel_level >= settled_reg) ? sel_level - settled_reg
                                                                  : settled_reg - sel_level;
                        phase_next   = 1'b0;
                        step_next    = '0;
                        ramping_next = 1'b1;
                    end
                    night_next = band_sel < ald_pkg::BAND_LIGHT_DAY;
                    day_next   = band_sel >= ald_pkg::BAND_LIGHT_DAY;
                end
            end
            ald_pkg::KIND_RAMP:
            begin
                if (ramping_reg)
                begin
                    duty_next  = ramp_duty;
                    written    = 1'b1;
                    phase_next = !phase_reg;
                    step_next  = step_inc;
                    // The last step lands exactly on the band level.
                    if (step_inc >= STEP_W'(RAMP_STEPS))
                    begin
                        ramping_next = 1'b0;
                        settled_next = level_reg;
                        duty_next    = level_reg;
                    end
                end
            end
            default:
            begin
                written = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (accept)
        begin
            out_valid_next               = 1'b1;
            out_item_next.lamp_enabled   = lamp_next;
            out_item_next.duty_percent   = duty_next;
            out_item_next.duty_written   = written;
            out_item_next.night_led      = night_next;
            out_item_next.day_led        = day_next;
            out_item_next.sample_request = request;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            pressed_reg   <= 1'b0;
            was_reg       <= 1'b0;
            lamp_reg      <= 1'b0;
            band_reg      <= ald_pkg::BAND_NONE;
            level_reg     <= '0;
            settled_reg   <= '0;
            span_reg      <= '0;
            rising_reg    <= 1'b1;
            phase_reg     <= 1'b0;
            step_reg      <= '0;
            ramping_reg   <= 1'b0;
            duty_reg      <= '0;
            night_reg     <= 1'b0;
            day_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                hist_reg    <= hist_next;
                pressed_reg <= pressed_next;
                was_reg     <= was_next;
                lamp_reg    <= lamp_next;
                band_reg    <= band_next;
                level_reg   <= level_next;
                settled_reg <= settled_next;
                span_reg    <= span_next;
                rising_reg  <= rising_next;
                phase_reg   <= phase_next;
                step_reg    <= step_next;
                ramping_reg <= ramping_next;
                duty_reg    <= duty_next;
                night_reg   <= night_next;
                day_reg     <= day_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.duty_percent <= ald_pkg::DUTY_MAX)
        else $error("duty above full scale");

    a_request_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.sample_request |-> out_item.lamp_enabled)
        else $error("conversion requested with lamp off");

    a_leds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({night_reg, day_reg}) && (lamp_reg || (!night_reg && !day_reg)))
        else $error("indicator LEDs inconsistent");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ramping_reg |-> step_reg < STEP_W'(RAMP_STEPS))
        else $error("ramp step out of range");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

endmodule

@@ tb/ambient_light_lamp_dimmer_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ambient light lamp dimmer testbench
// Drives tick requests and threshold writes into the dimmer, predicts every
// result with an independent model of the debounce, banding and ramp logic,
// and compares each result field by field under varying handshake pressure.
// ----------------------------------------------------------------------------
module ambient_light_lamp_dimmer_top_tb;

    // Tick kind that the block does not use; it must leave all state alone.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int CLK_PERIOD   = 8;
    localparam int RAMP_LEN     = ald_pkg::RAMP_STEPS_DEFAULT;
    localparam int DEB_LEN      = ald_pkg::DEBOUNCE_SAMPLES_DEFAULT;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PHASE_ITEMS  = 230;

    // ------------------------------------------------------------------------
    // Clock and block connections
    // ------------------------------------------------------------------------
    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    ald_pkg::ald_in_t            in_item;
    logic                        out_valid;
    logic                        out_ready;
    ald_pkg::ald_out_t           out_item;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ald_pkg::ADDR_W-1:0]  paddr;
    logic [ald_pkg::DATA_W-1:0]  pwdata;
    logic [ald_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    ambient_light_lamp_dimmer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------------
    // Results predicted for accepted requests, oldest first.
    ald_pkg::ald_out_t pending_results[$];

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int sender_idle_pct;
    int receiver_stall_pct;

    int errors;
    int requests_sent;
    int busy_requests;
    int results_checked;
    int threshold_writes;
    int lamp_toggles;
    int ramps_finished;

    // ------------------------------------------------------------------------
    // Dimmer model state. It follows the block request by request and is
    // advanced at the edge where a request is accepted.
    // ------------------------------------------------------------------------
    logic [ald_pkg::THR_W-1:0]   thr_night;
    logic [ald_pkg::THR_W-1:0]   thr_dusk;
    logic [ald_pkg::THR_W-1:0]   thr_dim;
    logic [ald_pkg::THR_W-1:0]   thr_bright;
    logic [DEB_LEN-1:0]          press_bits;
    logic                        btn_down;
    logic                        btn_down_prev;
    logic                        lamp_is_on;
    logic [2:0]                  cur_band;
    logic [ald_pkg::LEVEL_W-1:0] target_duty;
    logic [ald_pkg::LEVEL_W-1:0] base_duty;
    logic [ald_pkg::LEVEL_W-1:0] ramp_dist;
    logic                        going_up;
    logic                        half_tick;
    logic [3:0]                  step_idx;
    logic                        in_ramp;
    logic [ald_pkg::LEVEL_W-1:0] duty_now;
    logic                        night_on;
    logic                        day_on;

    task automatic clear_dimmer_model();
        thr_night     = ald_pkg::NIGHT_RESET;
        thr_dusk      = ald_pkg::DUSK_RESET;
        thr_dim       = ald_pkg::DIM_RESET;
        thr_bright    = ald_pkg::BRIGHT_RESET;
        press_bits    = '0;
        btn_down      = 1'b0;
        btn_down_prev = 1'b0;
        lamp_is_on    = 1'b0;
        cur_band      = ald_pkg::BAND_NONE;
        target_duty   = '0;
        base_duty     = '0;
        ramp_dist     = '0;
        going_up      = 1'b1;
        half_tick     = 1'b0;
        step_idx      = '0;
        in_ramp       = 1'b0;
        duty_now      = '0;
        night_on      = 1'b0;
        day_on        = 1'b0;
    endtask

    // Overshoot profile of the ramp in percent of the span; steps past the
    // end of the table hold at the full span.
    function automatic int overshoot_pct(input logic [3:0] step);
        case (step)
            4'd0:    return 0;
            4'd1:    return 10;
            4'd2:    return 20;
            4'd3:    return 80;
            4'd4:    return 130;
            4'd5:    return 130;
            4'd6:    return 120;
            4'd7:    return 110;
            4'd8:    return 105;
            default: return 100;
        endcase
    endfunction

    // Duty level that each light band settles to.
    function automatic logic [ald_pkg::LEVEL_W-1:0] band_target(input logic [2:0] band);
        case (band)
            ald_pkg::BAND_DEEP_NIGHT: return 7'd15;
            ald_pkg::BAND_NIGHT:      return 7'd20;
            ald_pkg::BAND_LIGHT_DAY:  return 7'd42;
            ald_pkg::BAND_DAY:        return 7'd80;
            default:                  return 7'd90;
        endcase
    endfunction

    // Advance the model by one accepted request and work out its result.
    // busy is set when the request does real work rather than being ignored.
    task automatic predict_dimmer(input ald_pkg::ald_in_t req,
                                  output ald_pkg::ald_out_t res,
                                  output bit busy);
        logic       held;
        logic [2:0] band;
        int         delta;
        int         level;
        bit         wrote;
        bit         want_sample;

        held        = (req.button_low == 1'b0);
        wrote       = 1'b0;
        want_sample = 1'b0;
        busy        = 1'b0;

        if (req.kind == ald_pkg::KIND_FAST)
        begin
            busy = 1'b1;
            press_bits = {press_bits[DEB_LEN-2:0], held};
            if (&press_bits)
                btn_down = 1'b1;
            else if (press_bits == '0)
                btn_down = 1'b0;
            // A fresh press toggles the lamp; switching off blanks everything.
            if (btn_down && !btn_down_prev)
            begin
                lamp_is_on = !lamp_is_on;
                lamp_toggles++;
                if (!lamp_is_on)
                begin
                    night_on = 1'b0;
                    day_on   = 1'b0;
                    duty_now = '0;
                    wrote    = 1'b1;
                end
            end
            btn_down_prev = btn_down;
            want_sample   = lamp_is_on;
        end
        else if (req.kind == ald_pkg::KIND_MEDIUM)
        begin
            if (lamp_is_on)
            begin
                busy = 1'b1;
                if (req.light_sample > thr_night)
                    band = ald_pkg::BAND_DEEP_NIGHT;
                else if (req.light_sample > thr_dusk)
                    band = ald_pkg::BAND_NIGHT;
                else if (req.light_sample > thr_dim)
                    band = ald_pkg::BAND_LIGHT_DAY;
                else if (req.light_sample > thr_bright)
                    band = ald_pkg::BAND_DAY;
                else
                    band = ald_pkg::BAND_BRIGHT_DAY;
                // Only a change of band restarts the ramp.
                if (band != cur_band)
                begin
                    cur_band    = band;
                    target_duty = band_target(band);
                    if (target_duty >= base_duty)
                    begin
                        going_up  = 1'b1;
                        ramp_dist = target_duty - base_duty;
                    end
                    else
                    begin
                        going_up  = 1'b0;
                        ramp_dist = base_duty - target_duty;
                    end
                    half_tick = 1'b0;
                    step_idx  = '0;
                    in_ramp   = 1'b1;
                end
                night_on = (band == ald_pkg::BAND_DEEP_NIGHT) ||
                           (band == ald_pkg::BAND_NIGHT);
                day_on   = !night_on;
            end
        end
        else if (req.kind == ald_pkg::KIND_RAMP)
        begin
            // The ramp runs on ramp ticks whether or not the lamp is on.
            if (in_ramp)
            begin
                busy  = 1'b1;
                delta = (overshoot_pct(step_idx) * int'(ramp_dist)) / 100;
                level = going_up ? int'(base_duty) + delta : int'(base_duty) - delta;
                if (level < 0)
                    level = 0;
                else if (level > int'(ald_pkg::DUTY_MAX))
                    level = int'(ald_pkg::DUTY_MAX);
                duty_now  = level[ald_pkg::LEVEL_W-1:0];
                wrote     = 1'b1;
                half_tick = !half_tick;
                if (!half_tick)
                    step_idx++;
                if (step_idx >= RAMP_LEN)
                begin
                    in_ramp   = 1'b0;
                    base_duty = target_duty;
                    duty_now  = target_duty;
                    ramps_finished++;
                end
            end
        end

        res.lamp_enabled   = lamp_is_on;
        res.duty_percent   = duty_now;
        res.duty_written   = wrote;
        res.night_led      = night_on;
        res.day_led        = day_on;
        res.sample_request = want_sample;
    endtask

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // ------------------------------------------------------------------------
    // Request sender. Called right after the previous acceptance; the valid
    // line is only ever changed at a falling edge, once per edge.
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic [1:0] kind, input logic button_low,
                             input logic [ald_pkg::THR_W-1:0] sample);
        ald_pkg::ald_in_t  req;
        ald_pkg::ald_out_t res;
        bit                busy;

        req.kind         = kind;
        req.button_low   = button_low;
        req.light_sample = sample;
        @(negedge clk);
        while (chance(sender_idle_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predict_dimmer(req, res, busy);
        pending_results.push_back(res);
        requests_sent++;
        if (busy)
            busy_requests++;
    endtask

    // Hold off new requests until every predicted result has been taken,
    // then let the output register settle.
    task automatic drain_results();
        int waited;

        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        repeat (2) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration access. A write is followed by a read of the same
    // register so that the stored value is seen. Only used while idle.
    // ------------------------------------------------------------------------
    task automatic write_threshold(input logic [1:0] idx,
                                   input logic [ald_pkg::THR_W-1:0] value);
        logic [ald_pkg::DATA_W-1:0] data;
        logic [ald_pkg::THR_W-1:0]  stored;

        // Upper data bits are noise; only the low ten bits are kept.
        data = $urandom;
        data[ald_pkg::THR_W-1:0] = value;

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            ald_pkg::REG_NIGHT: thr_night  = value;
            ald_pkg::REG_DUSK:  thr_dusk   = value;
            ald_pkg::REG_DIM:   thr_dim    = value;
            default:            thr_bright = value;
        endcase
        threshold_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        stored = prdata[ald_pkg::THR_W-1:0];
        if (stored !== value)
        begin
            $error("threshold %0d readback mismatch: expected %0d, actual %0d",
                   idx, value, stored);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all_thresholds(input logic [ald_pkg::THR_W-1:0] night,
                                        input logic [ald_pkg::THR_W-1:0] dusk,
                                        input logic [ald_pkg::THR_W-1:0] dim,
                                        input logic [ald_pkg::THR_W-1:0] bright);
        drain_results();
        write_threshold(ald_pkg::REG_NIGHT, night);
        write_threshold(ald_pkg::REG_DUSK, dusk);
        write_threshold(ald_pkg::REG_DIM, dim);
        write_threshold(ald_pkg::REG_BRIGHT, bright);
    endtask

    // ------------------------------------------------------------------------
    // Result checker. The receiver's ready is changed at falling edges and
    // each result is taken at the rising edge where valid and ready meet.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int expected,
                                        input int actual);
        if (expected != actual)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            errors++;
        end
    endfunction

    initial
    begin
        ald_pkg::ald_out_t want;

        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result arrived with no request waiting for it");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    check_field("lamp_enabled", want.lamp_enabled, out_item.lamp_enabled);
                    check_field("duty_percent", want.duty_percent, out_item.duty_percent);
                    check_field("duty_written", want.duty_written, out_item.duty_written);
                    check_field("night_led", want.night_led, out_item.night_led);
                    check_field("day_led", want.day_led, out_item.day_led);
                    check_field("sample_request", want.sample_request,
                                out_item.sample_request);
                end
            end
            @(negedge clk);
            out_ready <= !chance(receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Random traffic. Most of it is shaped into real use: button presses
    // with some contact bounce, and light samples each followed by a random run
    // of mostly ramp ticks, not always enough to finish a ramp. The rest is plain noise.
    // ------------------------------------------------------------------------
    function automatic logic [ald_pkg::THR_W-1:0] pick_sample();
        int pick;
        int base;

        if (chance(50))
            return ald_pkg::THR_W'($urandom_range(1023, 0));
        // Land on or right next to one of the thresholds.
        case ($urandom_range(3, 0))
            0:       base = thr_night;
            1:       base = thr_dusk;
            2:       base = thr_dim;
            default: base = thr_bright;
        endcase
        pick = base + $urandom_range(2, 0) - 1;
        if (pick < 0)
            pick = 0;
        else if (pick > 1023)
            pick = 1023;
        return ald_pkg::THR_W'(pick);
    endfunction

    task automatic run_episode();
        int roll;
        int count;
        int i;

        roll = $urandom_range(99, 0);
        if (roll < (lamp_is_on ? 20 : 50))
        begin
            // Hold the button, then let go; a bounce now and then.
            count = $urandom_range(8, 3);
            for (i = 0; i < count; i++)
                send_tick(ald_pkg::KIND_FAST, chance(10) ? 1'b1 : 1'b0,
                          ald_pkg::THR_W'($urandom));
            count = $urandom_range(8, 3);
            for (i = 0; i < count; i++)
                send_tick(ald_pkg::KIND_FAST, chance(10) ? 1'b0 : 1'b1,
                          ald_pkg::THR_W'($urandom));
        end
        else if (roll < 88)
        begin
            send_tick(ald_pkg::KIND_MEDIUM, 1'($urandom), pick_sample());
            count = $urandom_range(24, 0);
            for (i = 0; i < count; i++)
            begin
                if (chance(15))
                    send_tick(ald_pkg::KIND_FAST, 1'b1, ald_pkg::THR_W'($urandom));
                else
                    send_tick(ald_pkg::KIND_RAMP, 1'($urandom), ald_pkg::THR_W'($urandom));
            end
        end
        else
        begin
            count = $urandom_range(4, 1);
            for (i = 0; i < count; i++)
                send_tick(2'($urandom_range(3, 0)), 1'($urandom),
                          ald_pkg::THR_W'($urandom));
        end
    endtask

    task automatic run_episodes(input int item_goal);
        int start;

        start = requests_sent;
        while (requests_sent - start < item_goal)
            run_episode();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // With the lamp off a light sample is ignored, a ramp tick finds no ramp
    // and the spare kind changes nothing.
    task automatic test_idle_ticks();
        send_tick(KIND_SPARE, 1'b0, 10'h3FF);
        send_tick(ald_pkg::KIND_MEDIUM, 1'b1, 10'h3FF);
        send_tick(ald_pkg::KIND_RAMP, 1'b0, 10'h000);
    endtask

    // A bounce breaks the run of held samples; the next full run of held
    // samples counts as a press and turns the lamp on.
    task automatic test_debounce_toggle();
        int i;

        send_tick(ald_pkg::KIND_FAST, 1'b0, 10'h000);
        send_tick(ald_pkg::KIND_FAST, 1'b1, 10'h3FF);
        for (i = 0; i < DEB_LEN; i++)
            send_tick(ald_pkg::KIND_FAST, 1'b0, 10'h155);
    endtask

    // Darkest sample, a sample exactly on a threshold, the same band again,
    // and the brightest sample, then the first ticks of the ramp.
    task automatic test_band_sorting();
        send_tick(ald_pkg::KIND_MEDIUM, 1'b0, 10'h3FF);
        send_tick(ald_pkg::KIND_MEDIUM, 1'b1, ald_pkg::NIGHT_RESET);
        send_tick(ald_pkg::KIND_MEDIUM, 1'b0, ald_pkg::NIGHT_RESET);
        send_tick(ald_pkg::KIND_MEDIUM, 1'b1, 10'h000);
        send_tick(ald_pkg::KIND_RAMP, 1'b1, 10'h2AA);
        send_tick(ald_pkg::KIND_RAMP, 1'b0, 10'h155);
    endtask

    // Release, press again to switch the lamp off, and keep ramping.
    task automatic test_ramp_after_off();
        int i;

        for (i = 0; i < DEB_LEN; i++)
            send_tick(ald_pkg::KIND_FAST, 1'b1, 10'h000);
        for (i = 0; i < DEB_LEN; i++)
            send_tick(ald_pkg::KIND_FAST, 1'b0, 10'h3FF);
        send_tick(ald_pkg::KIND_RAMP, 1'b1, 10'h000);
    endtask

    // Threshold settings at the extremes, inverted and random, each with
    // some traffic behind it.
    task automatic test_threshold_settings();
        write_all_thresholds(10'd0, 10'd0, 10'd0, 10'd0);
        run_episodes(20);
        write_all_thresholds(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        run_episodes(20);
        write_all_thresholds(10'd0, 10'd341, 10'd682, 10'd1023);
        run_episodes(20);
        write_all_thresholds(ald_pkg::THR_W'($urandom), ald_pkg::THR_W'($urandom),
                             ald_pkg::THR_W'($urandom), ald_pkg::THR_W'($urandom));
        run_episodes(20);
    endtask

    // Long random traffic under four kinds of handshake pressure. Between
    // phases the sender waits for every result and the thresholds change.
    task automatic test_random_traffic();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_all_thresholds(ald_pkg::NIGHT_RESET, ald_pkg::DUSK_RESET,
                             ald_pkg::DIM_RESET, ald_pkg::BRIGHT_RESET);
        run_episodes(PHASE_ITEMS);

        sender_idle_pct    = 79;
        receiver_stall_pct = 0;
        write_all_thresholds(10'd900, 10'd600, 10'd250, 10'd100);
        run_episodes(PHASE_ITEMS);

        sender_idle_pct    = 0;
        receiver_stall_pct = 79;
        write_all_thresholds(ald_pkg::THR_W'($urandom_range(1023, 700)),
                             ald_pkg::THR_W'($urandom_range(699, 450)),
                             ald_pkg::THR_W'($urandom_range(449, 200)),
                             ald_pkg::THR_W'($urandom_range(199, 0)));
        run_episodes(PHASE_ITEMS);

        sender_idle_pct    = 26;
        receiver_stall_pct = 26;
        write_all_thresholds(ald_pkg::NIGHT_RESET, ald_pkg::DUSK_RESET,
                             ald_pkg::DIM_RESET, ald_pkg::BRIGHT_RESET);
        run_episodes(PHASE_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        in_item            = '0;
        out_ready          = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        errors             = 0;
        requests_sent      = 0;
        busy_requests      = 0;
        results_checked    = 0;
        threshold_writes   = 0;
        lamp_toggles       = 0;
        ramps_finished     = 0;
        clear_dimmer_model();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_ticks();
        test_debounce_toggle();
        test_band_sorting();
        test_ramp_after_off();
        test_threshold_settings();
        test_random_traffic();
        drain_results();

        $display("Covered %0d requests (%0d doing work), %0d results checked.",
                 requests_sent, busy_requests, results_checked);
        $display("Lamp toggled %0d times, %0d ramps ran to the end, %0d threshold writes.",
                 lamp_toggles, ramps_finished, threshold_writes);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ald_pkg.sv
rtl/ambient_light_lamp_dimmer_top.sv
tb/ambient_light_lamp_dimmer_top_tb.sv
